[design/rrpo_pkg.sv]
// ---------------------------------------------------------------------------
// rrpo_pkg: shared types, codes and widths for the residue ring power and
// order block.
// ---------------------------------------------------------------------------
`default_nettype none
package rrpo_pkg;

  localparam int W = 16;

  // Group kinds.
  localparam logic [1:0] KIND_UNDEF = 2'd0;
  localparam logic [1:0] KIND_ADD   = 2'd1;
  localparam logic [1:0] KIND_MUL   = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_UNDEF  = 2'd1;
  localparam logic [1:0] ST_NOUNIT = 2'd2;

  // Request types.
  localparam logic REQ_POW = 1'b0;
  localparam logic REQ_ORD = 1'b1;

  // Register indexes.
  localparam logic REG_MODULUS = 1'b0;
  localparam logic REG_KIND    = 1'b1;

  typedef struct packed {
    logic          req_type;
    logic [W-1:0]  operand_a;
    logic [W-1:0]  exponent;
  } req_t;

  typedef struct packed {
    logic [W-1:0]  value;
    logic [W-1:0]  generator_count;
    logic [1:0]    status;
  } res_t;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,     // latch request, n
    OP_MOD,      // x = a mod n start
    OP_MODX,     // x = b mod n (b = ord/p etc)
    OP_MUL,      // r = r*b mod n
    OP_SQR,      // b = b*b mod n
    OP_DIV,      // generic divide q=num/den, rem
    OP_SET       // register moves per sel
  } op_t;

  typedef enum logic [5:0] {
    S_IDLE, S_LOAD, S_LOADW,
    S_TOT_INIT, S_TOT_TEST, S_TOT_DIVW, S_TOT_CHK, S_TOT_STRIP, S_TOT_SDIVW,
    S_TOT_SCHK, S_TOT_RSUB, S_TOT_RSUBW, S_TOT_ADV, S_TOT_END, S_TOT_ENDW,
    S_TOT_DONE,
    S_DISPATCH,
    S_PW_INIT, S_PW_STEP, S_PW_WAIT, S_PW_DONE,
    S_GCD_STEP, S_GCD_WAIT, S_GCD_Q, S_GCD_QW,
    S_MO_START, S_MO_CHK1, S_MO_PTEST, S_MO_PTESTW, S_MO_RSTRIP, S_MO_RSTRIPW,
    S_MO_OTRY, S_MO_OTRYW, S_MO_OPOW, S_MO_OPOWD, S_MO_ADV, S_MO_LAST,
    S_MO_LASTW, S_MO_LPOW, S_MO_LPOWD,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

[design/residue_ring_power_and_order_top.sv]
// ---------------------------------------------------------------------------
// residue_ring_power_and_order_top
// Power/multiple and element order over Z_n or Z_n*.
// ---------------------------------------------------------------------------
// Usage: write modulus (index 0) and group_kind (index 1) through
// cfg_we/cfg_index/cfg_data while idle. Pulse start with a request when
// busy is low; busy rises next cycle. One result appears on result with
// done high for exactly one cycle; the receiver cannot stall it.
// The totient trial division, square-and-multiply and divisor search all
// share one bit-serial divider, so the time a request takes depends on
// the data, and is longest for large prime-rich moduli.
// One request is in flight at a time.
// Reset sets modulus 1 and group kind undefined, and returns to idle.
// ---------------------------------------------------------------------------
`default_nettype none
module residue_ring_power_and_order_top
  import rrpo_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire req_t        request,
  output logic             done,
  output res_t             result,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [W-1:0] cfg_data
);
  logic [W-1:0] modulus;
  logic [1:0]   kind;
  req_t         req_q;
  state_t       state;
  state_t       ret;
  logic div_done, f_zero_rem, f_p_small, f_e_zero, f_x_gt1, f_tot_second;
  logic f_add, f_mul, f_ord, f_is_one, f_b_zero, f_x_zero;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= W'(1);
      kind    <= KIND_UNDEF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODULUS: modulus <= cfg_data;
        REG_KIND:    kind    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted beat.
  always_ff @(posedge clk) begin
    if (start && !busy) req_q <= request;
  end

  rrpo_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .div_done(div_done),
    .f_zero_rem(f_zero_rem), .f_p_small(f_p_small), .f_e_zero(f_e_zero),
    .f_x_gt1(f_x_gt1), .f_tot_second(f_tot_second), .f_add(f_add),
    .f_mul(f_mul), .f_ord(f_ord), .f_is_one(f_is_one), .f_b_zero(f_b_zero),
    .f_x_zero(f_x_zero), .state(state), .ret(ret), .busy(busy)
  );

  rrpo_dp u_dp (
    .clk(clk), .rst(rst), .state(state), .ret(ret), .req(req_q), .modulus(modulus),
    .kind(kind), .div_done(div_done), .f_zero_rem(f_zero_rem),
    .f_p_small(f_p_small), .f_e_zero(f_e_zero), .f_x_gt1(f_x_gt1),
    .f_tot_second(f_tot_second), .f_add(f_add), .f_mul(f_mul), .f_ord(f_ord),
    .f_is_one(f_is_one), .f_b_zero(f_b_zero), .f_x_zero(f_x_zero),
    .res(result), .res_valid(done)
  );
endmodule
`default_nettype wire

[design/rrpo_div.sv]
// ---------------------------------------------------------------------------
// rrpo_div: restoring divider, one quotient bit per cycle.
// Dividend up to 2W bits, divisor W bits.
// ---------------------------------------------------------------------------
`default_nettype none
module rrpo_div
  import rrpo_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           go,
  input  wire logic [2*W-1:0] num,
  input  wire logic [W-1:0]   den,
  output logic                done,
  output logic [2*W-1:0]      quo,
  output logic [W-1:0]        rem
);
  localparam int CW = $clog2(2*W+1);

  logic [CW-1:0]  cnt;
  logic           run;
  logic [W:0]     part;
  logic [2*W-1:0] q;
  logic [W-1:0]   d;
  logic [W:0]     trial;
  logic [W:0]     shifted;

  // Shift in one dividend bit and trial-subtract.
  always_comb begin
    shifted = {part[W-1:0], q[2*W-1]};
    trial   = shifted - {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run  <= 1'b1;
        cnt  <= CW'(2*W);
        part <= '0;
        q    <= num;
        d    <= den;
      end else if (run) begin
        if (!trial[W]) begin
          part <= trial;
          q    <= {q[2*W-2:0], 1'b1};
        end else begin
          part <= shifted;
          q    <= {q[2*W-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = q;
  assign rem = part[W-1:0];
endmodule
`default_nettype wire

[design/rrpo_ctrl.sv]
// ---------------------------------------------------------------------------
// rrpo_ctrl: sequencer for totient, power, gcd and order searches.
// Drives the datapath by a state code; reads back its flags.
// ---------------------------------------------------------------------------
`default_nettype none
module rrpo_ctrl
  import rrpo_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   start,
  input  wire logic   div_done,
  input  wire logic   f_zero_rem,   // divider remainder is zero
  input  wire logic   f_p_small,    // p*p <= x
  input  wire logic   f_e_zero,     // exponent exhausted
  input  wire logic   f_x_gt1,      // x > 1
  input  wire logic   f_tot_second, // second totient pass pending
  input  wire logic   f_add,
  input  wire logic   f_mul,
  input  wire logic   f_ord,
  input  wire logic   f_is_one,     // pow result equals 1 mod n
  input  wire logic   f_b_zero,     // gcd divisor zero
  input  wire logic   f_x_zero,     // reduced operand zero
  output state_t      state,
  output state_t      ret,          // where a power call returns
  output logic        busy
);
  state_t nxt;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= nxt;
  end

  // Record the return point of each power call.
  always_ff @(posedge clk) begin
    if (rst) begin
      ret <= S_IDLE;
    end else begin
      case (state)
        S_DISPATCH: ret <= S_PW_DONE;
        S_MO_START: ret <= S_MO_CHK1;
        S_MO_OPOW:  ret <= S_MO_OPOWD;
        S_MO_LPOW:  ret <= S_MO_LPOWD;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    nxt = state;
    case (state)
      S_IDLE:      if (start) nxt = S_LOAD;
      S_LOAD:      nxt = S_LOADW;
      S_LOADW:     if (div_done) nxt = (f_add || f_mul) ? S_TOT_INIT : S_OUT;
      S_TOT_INIT:  nxt = S_TOT_TEST;
      S_TOT_TEST:  nxt = f_p_small ? S_TOT_DIVW : S_TOT_END;
      S_TOT_DIVW:  if (div_done) nxt = S_TOT_CHK;
      S_TOT_CHK:   nxt = f_zero_rem ? S_TOT_STRIP : S_TOT_ADV;
      S_TOT_STRIP: nxt = S_TOT_SDIVW;
      S_TOT_SDIVW: if (div_done) nxt = S_TOT_SCHK;
      S_TOT_SCHK:  nxt = f_zero_rem ? S_TOT_STRIP : S_TOT_RSUB;
      S_TOT_RSUB:  nxt = S_TOT_RSUBW;
      S_TOT_RSUBW: if (div_done) nxt = S_TOT_ADV;
      S_TOT_ADV:   nxt = S_TOT_TEST;
      S_TOT_END:   nxt = f_x_gt1 ? S_TOT_ENDW : S_TOT_DONE;
      S_TOT_ENDW:  if (div_done) nxt = S_TOT_DONE;
      S_TOT_DONE:  nxt = f_tot_second ? S_TOT_INIT : S_DISPATCH;
      S_DISPATCH:  begin
        if (!f_ord)     nxt = S_PW_INIT;
        else if (f_add) nxt = f_x_zero ? S_OUT : S_GCD_STEP;
        else            nxt = S_MO_START;
      end
      S_PW_INIT:   nxt = S_PW_STEP;
      S_PW_STEP:   nxt = f_e_zero ? ret : S_PW_WAIT;
      S_PW_WAIT:   if (div_done) nxt = S_PW_STEP;
      S_PW_DONE:   nxt = S_OUT;
      S_GCD_STEP:  nxt = f_b_zero ? S_GCD_Q : S_GCD_WAIT;
      S_GCD_WAIT:  if (div_done) nxt = S_GCD_STEP;
      S_GCD_Q:     nxt = S_GCD_QW;
      S_GCD_QW:    if (div_done) nxt = S_OUT;
      S_MO_START:  nxt = S_PW_INIT;
      S_MO_CHK1:   nxt = f_is_one ? S_MO_PTEST : S_OUT;
      S_MO_PTEST:  nxt = f_p_small ? S_MO_PTESTW : S_MO_LAST;
      S_MO_PTESTW: if (div_done) nxt = f_zero_rem ? S_MO_RSTRIP : S_MO_ADV;
      S_MO_RSTRIP: nxt = S_MO_RSTRIPW;
      S_MO_RSTRIPW: if (div_done) nxt = f_zero_rem ? S_MO_RSTRIP : S_MO_OTRY;
      S_MO_OTRY:   nxt = S_MO_OTRYW;
      S_MO_OTRYW:  if (div_done) nxt = f_zero_rem ? S_MO_OPOW : S_MO_ADV;
      S_MO_OPOW:   nxt = S_PW_INIT;
      S_MO_OPOWD:  nxt = f_is_one ? S_MO_OTRY : S_MO_ADV;
      S_MO_ADV:    nxt = S_MO_PTEST;
      S_MO_LAST:   nxt = f_x_gt1 ? S_MO_LASTW : S_OUT;
      S_MO_LASTW:  if (div_done) nxt = f_zero_rem ? S_MO_LPOW : S_OUT;
      S_MO_LPOW:   nxt = S_PW_INIT;
      S_MO_LPOWD:  nxt = f_is_one ? S_MO_LAST : S_OUT;
      S_OUT:       nxt = S_IDLE;
      default:     nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    busy = (state != S_IDLE);
  end
endmodule
`default_nettype wire

[design/rrpo_dp.sv]
// ---------------------------------------------------------------------------
// rrpo_dp: working registers, shared divider and multipliers for the
// residue ring engine. Each controller state selects its register updates.
// ---------------------------------------------------------------------------
`default_nettype none
module rrpo_dp
  import rrpo_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire state_t      state,
  input  wire state_t      ret,
  input  wire req_t        req,
  input  wire logic [W-1:0] modulus,
  input  wire logic [1:0]  kind,
  output logic             div_done,
  output logic             f_zero_rem,
  output logic             f_p_small,
  output logic             f_e_zero,
  output logic             f_x_gt1,
  output logic             f_tot_second,
  output logic             f_add,
  output logic             f_mul,
  output logic             f_ord,
  output logic             f_is_one,
  output logic             f_b_zero,
  output logic             f_x_zero,
  output res_t             res,
  output logic             res_valid
);
  // Request and configuration snapshot.
  logic [W-1:0] n, k;
  logic [1:0]   knd;
  logic         ord;
  // Totient engine.
  logic [W-1:0] tx, tr, tp, ph1, ph2;
  logic         pass2;
  // Power engine.
  logic [W-1:0] pr, pb, pe;
  // Order search and gcd.
  logic [W-1:0] ox, ord_v, rest, mp, ga, gb, val;
  logic [1:0]   st;

  logic           go;
  logic [2*W-1:0] num, quo;
  logic [W-1:0]   den, rem;
  logic [2*W-1:0] prod;
  logic [1:0]     pw_phase;

  rrpo_div u_div (
    .clk(clk), .rst(rst), .go(go), .num(num), .den(den),
    .done(div_done), .quo(quo), .rem(rem)
  );

  // Divider operand selection by state.
  always_comb begin
    go  = 1'b0;
    num = '0;
    den = n;
    prod = '0;
    case (state)
      S_TOT_TEST: begin
        go = f_p_small; num = {{W{1'b0}}, tx}; den = tp;
      end
      S_TOT_STRIP: begin
        go = 1'b1; num = {{W{1'b0}}, tx}; den = tp;
      end
      S_TOT_RSUB: begin
        go = 1'b1; num = {{W{1'b0}}, tr}; den = tp;
      end
      S_TOT_END: begin
        go = f_x_gt1; num = {{W{1'b0}}, tr}; den = tx;
      end
      S_PW_STEP: begin
        if (!f_e_zero) begin
          go = 1'b1;
          // Additive mode doubles and adds; multiplicative squares and multiplies.
          if (pw_phase == 2'd0) begin
            if (!pe[0])               prod = {{W{1'b0}}, pr};
            else if (knd == KIND_ADD) prod = {{(W-1){1'b0}}, {1'b0, pr} + {1'b0, pb}};
            else                      prod = pr * pb;
          end else begin
            if (knd == KIND_ADD) prod = {{(W-1){1'b0}}, {1'b0, pb} + {1'b0, pb}};
            else                 prod = pb * pb;
          end
          num = prod;
        end
      end
      S_PW_INIT: begin
        go = 1'b0;
      end
      S_GCD_STEP: begin
        go = !f_b_zero; num = {{W{1'b0}}, ga}; den = gb;
      end
      S_GCD_Q: begin
        go = 1'b1; num = {{W{1'b0}}, n}; den = ga;
      end
      S_MO_PTEST: begin
        go = f_p_small; num = {{W{1'b0}}, rest}; den = tp;
      end
      S_MO_RSTRIP: begin
        go = 1'b1; num = {{W{1'b0}}, rest}; den = tp;
      end
      S_MO_OTRY: begin
        go = 1'b1; num = {{W{1'b0}}, ord_v}; den = tp;
      end
      S_MO_LAST: begin
        go = f_x_gt1; num = {{W{1'b0}}, ord_v}; den = rest;
      end
      S_LOAD: begin
        go = 1'b1; num = {{W{1'b0}}, req.operand_a};
        den = (modulus == '0) ? W'(1) : modulus;
      end
      default: go = 1'b0;
    endcase
  end

  // Flags.
  logic [2*W-1:0] psq;
  logic [W-1:0]   lim;
  assign lim = (state == S_MO_PTEST) ? rest : tx;
  assign psq = tp * tp;
  assign f_p_small    = (psq <= {{W{1'b0}}, lim});
  assign f_zero_rem   = (rem == '0);
  assign f_e_zero     = (pe == '0) && (pw_phase == 2'd0);
  assign f_x_gt1      = (state == S_MO_LAST) ? (rest > W'(1)) : (tx > W'(1));
  assign f_tot_second = !pass2 && (knd == KIND_MUL);
  assign f_add        = (knd == KIND_ADD);
  assign f_mul        = (knd == KIND_MUL);
  assign f_ord        = ord;
  assign f_is_one     = (pr == ((n == W'(1)) ? W'(0) : W'(1)));
  assign f_b_zero     = (gb == '0);
  assign f_x_zero     = (ox == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      pass2     <= 1'b0;
      pw_phase  <= 2'd0;
    end else begin
      res_valid <= 1'b0;
      case (state)
        // Snapshot the request.
        S_LOAD: begin
          n     <= (modulus == '0) ? W'(1) : modulus;
          k     <= req.exponent;
          ord   <= req.req_type;
          knd   <= kind;
          pass2 <= 1'b0;
          st    <= (kind == KIND_ADD || kind == KIND_MUL) ? ST_OK : ST_UNDEF;
          val   <= '0;
          ph1   <= '0;
          ph2   <= '0;
        end
        // Keep the operand reduced mod n.
        S_LOADW: if (div_done) ox <= rem;
        // Totient of n (first pass) or of phi(n) (second pass).
        S_TOT_INIT: begin
          tx <= pass2 ? ph1 : n;
          tr <= pass2 ? ph1 : n;
          tp <= W'(2);
        end
        S_TOT_CHK: if (f_zero_rem) tx <= quo[W-1:0];
        S_TOT_SCHK: if (f_zero_rem) tx <= quo[W-1:0];
        S_TOT_RSUBW: if (div_done) tr <= tr - quo[W-1:0];
        S_TOT_ADV: tp <= tp + W'(1);
        S_TOT_ENDW: if (div_done) tr <= tr - quo[W-1:0];
        S_TOT_DONE: begin
          if (!pass2) ph1 <= tr;
          else        ph2 <= tr;
          pass2 <= f_tot_second;
        end
        // Pick the job.
        S_DISPATCH: begin
          ga <= n;
          gb <= ox;
          if (!ord) begin
            if (knd == KIND_ADD) begin
              pr  <= '0; pb <= ox; pe <= k;
            end
          end else if (knd == KIND_ADD && ox == '0) begin
            val <= W'(1);
          end
        end
        // Square-and-multiply, or shift-and-add in additive mode.
        S_PW_INIT: begin
          pw_phase <= 2'd0;
          if (knd == KIND_MUL) begin
            pr <= (n == W'(1)) ? W'(0) : W'(1);
            pb <= ox;
            case (ret)
              S_MO_CHK1:  pe <= ph1;
              S_MO_OPOWD: pe <= mp;
              S_MO_LPOWD: pe <= mp;
              default:    pe <= k;
            endcase
          end
        end
        S_PW_WAIT: if (div_done) begin
          if (pw_phase == 2'd0) begin
            pr <= rem; pw_phase <= 2'd1;
          end else begin
            pb <= rem; pw_phase <= 2'd0; pe <= pe >> 1;
          end
        end
        S_PW_DONE: val <= pr;
        // Euclid, then n / gcd.
        S_GCD_WAIT: if (div_done) begin
          ga <= gb; gb <= rem;
        end
        S_GCD_QW: if (div_done) val <= quo[W-1:0];
        // Multiplicative order.
        S_MO_CHK1: begin
          ord_v <= ph1; rest <= ph1; tp <= W'(2);
          if (!f_is_one) st <= ST_NOUNIT;
        end
        S_MO_PTESTW: if (div_done) begin
          if (f_zero_rem) rest <= quo[W-1:0];
        end
        S_MO_RSTRIPW: if (div_done && f_zero_rem) rest <= quo[W-1:0];
        S_MO_OTRYW: if (div_done) mp <= quo[W-1:0];
        S_MO_OPOWD: if (f_is_one) ord_v <= mp;
        S_MO_ADV: tp <= tp + W'(1);
        S_MO_LASTW: if (div_done) mp <= quo[W-1:0];
        S_MO_LPOWD: begin
          if (f_is_one) ord_v <= mp;
          else          val   <= ord_v;
        end
        S_MO_LAST: if (!f_x_gt1) val <= ord_v;
        S_OUT: res_valid <= 1'b1;
        default: ;
      endcase
      // The restrip wait with nonzero remainder falls to OTRY; last divide
      // with nonzero remainder ends the search.
      if (state == S_MO_LASTW && div_done && !f_zero_rem) val <= ord_v;
    end
  end

  // Result assembly.
  always_comb begin
    res.status          = st;
    res.value           = (st == ST_OK) ? val : '0;
    res.generator_count = (knd == KIND_ADD) ? ph1 : (knd == KIND_MUL) ? ph2 : '0;
  end

  // A result appears only in the cycle after the output state.
  a_valid_out: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $past(state == S_OUT))
    else $error("result strobe without output state");
  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    div_done |=> !div_done)
    else $error("divider done held");
  a_st_val: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status != ST_OK) |-> (res.value == '0))
    else $error("nonzero value with error status");
endmodule
`default_nettype wire
